// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// File: hdl/sfrf_pkg.sv
// Shared constants and types for the SYN flood rate filter.
// No dependencies.
package sfrf_pkg;
  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [31:0] NS_PER_SEC      = 32'd1000000000;
  localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;
  localparam logic [31:0] WINDOW_RST      = 32'd1000000000;
  localparam logic [15:0] THRESH_RST      = 16'd200;
  localparam logic [15:0] QSEC_RST        = 16'd60;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;
  localparam logic [1:0] REG_QSEC   = 2'd2;

  typedef enum logic [2:0] {
    CLS_NON_IPV4   = 3'd0,
    CLS_NON_TCP    = 3'd1,
    CLS_NOT_SYN    = 3'd2,
    CLS_NEW_SRC    = 3'd3,
    CLS_WIN_RESET  = 3'd4,
    CLS_UNDER      = 3'd5,
    CLS_QUAR_DROP  = 3'd6,
    CLS_NEW_QUAR   = 3'd7
  } pkt_class_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [63:0] win_start;
    logic [16:0] count;
    logic        qactive;
    logic [63:0] qexpiry;
  } entry_t;
endpackage

// File: hdl/syn_flood_rate_filter.sv
// Path from accept to result strobe: a passed packet finishes in S_READ, a pure
// SYN in S_EVAL, and a SYN that starts a quarantine in S_MUL (extra expiry multiply stage).
// One packet at a time: busy is low only in idle, so the next accept can come
// at the earliest in the same cycle as the result strobe.
// After reset a clearing pass writes every table entry, with busy high;
// configuration writes are taken throughout. Results cannot be stalled.
module syn_flood_rate_filter import sfrf_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IW = $clog2(TABLE_DEPTH)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] pkt_len,
  input  logic [15:0] ether_type,
  input  logic [3:0]  ip_ihl,
  input  logic [7:0]  ip_proto,
  input  logic [31:0] src_addr,
  input  logic [3:0]  tcp_doff,
  input  logic        flag_syn,
  input  logic        flag_ack,
  input  logic [63:0] now_ns,
  output logic        result_valid,
  output logic        drop,
  output logic [2:0]  pkt_class,
  output logic        event_valid,
  output logic [31:0] event_src,
  output logic [15:0] event_ttl,
  output logic [63:0] event_time_ns
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_MUL} state_t;

  state_t      state;
  logic [IW-1:0] clr_cnt;
  logic [31:0] win_len;
  logic [15:0] syn_threshold;
  logic [15:0] quarantine_seconds;

  logic [31:0] src_q;
  logic [63:0] now_q;
  logic [IW-1:0] idx_q;
  logic        syn_path;
  pkt_class_t  pre_class;
  logic [63:0] qprod;
  entry_t      upd;

  entry_t      rd_data;
  logic [IW-1:0] rd_addr;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  entry_t      wr_data;

  logic [31:0] hash;
  logic [31:0] len32, ip_end;
  pkt_class_t  cls_in;
  logic        pass_in;

  assign busy = (state != S_IDLE);
  assign hash = src_addr ^ {16'd0, src_addr[31:16]};

  // Read the incoming slot at accept, then hold the captured slot.
  assign rd_addr = (state == S_IDLE) ? hash[IW-1:0] : idx_q;

  // Classify the header checks at acceptance.
  always_comb begin
    len32   = {16'd0, pkt_len};
    ip_end  = 32'd14 + {26'd0, ip_ihl, 2'b00};
    pass_in = 1'b1;
    cls_in  = CLS_NON_IPV4;
    if (len32 < 32'd14 || ether_type != ETHERTYPE_IPV4) begin
      cls_in = CLS_NON_IPV4;
    end else if (len32 < 32'd34 || ip_end > len32 || ip_proto != PROTO_TCP) begin
      cls_in = CLS_NON_TCP;
    end else if (ip_end + 32'd20 > len32 || ip_end + {26'd0, tcp_doff, 2'b00} > len32
                 || !(flag_syn && !flag_ack)) begin
      cls_in = CLS_NOT_SYN;
    end else begin
      pass_in = 1'b0;
    end
  end

  // Evaluate the looked-up entry.
  logic        hit, qhold, win_rst;
  logic [16:0] cnt_inc;
  entry_t      ev_entry;
  pkt_class_t  ev_class;
  always_comb begin
    hit      = rd_data.valid && (rd_data.tag == src_q);
    qhold    = rd_data.qactive && (now_q < rd_data.qexpiry);
    win_rst  = (now_q - rd_data.win_start) > {32'd0, win_len};
    cnt_inc  = (rd_data.count < COUNT_MAX) ? rd_data.count + 17'd1 : rd_data.count;
    ev_entry = rd_data;
    ev_class = CLS_UNDER;
    if (!hit) begin
      ev_entry = '{valid: 1'b1, tag: src_q, win_start: now_q, count: 17'd1,
                   qactive: 1'b0, qexpiry: 64'd0};
      ev_class = CLS_NEW_SRC;
    end else if (qhold) begin
      ev_class = CLS_QUAR_DROP;
    end else begin
      ev_entry.qactive = 1'b0;
      if (win_rst) begin
        ev_entry.win_start = now_q;
        ev_entry.count     = 17'd1;
        ev_class           = CLS_WIN_RESET;
      end else begin
        ev_entry.count = cnt_inc;
        if (cnt_inc <= {1'b0, syn_threshold}) ev_class = CLS_UNDER;
        else ev_class = CLS_NEW_QUAR;
      end
    end
  end

  // Table write port: clearing pass, evaluation or quarantine set.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = upd;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
      end
      S_EVAL: begin
        wr_en   = (ev_class != CLS_QUAR_DROP) && (ev_class != CLS_NEW_QUAR);
        wr_data = ev_entry;
      end
      S_MUL: begin
        wr_en   = 1'b1;
        wr_data = upd;
        wr_data.qactive = 1'b1;
        wr_data.qexpiry = now_q + qprod;
      end
      default: ;
    endcase
  end

  sfrf_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len            <= WINDOW_RST;
      syn_threshold      <= THRESH_RST;
      quarantine_seconds <= QSEC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW: win_len            <= cfg_data;
        REG_THRESH: syn_threshold      <= cfg_data[15:0];
        REG_QSEC:   quarantine_seconds <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequence one transaction at a time and register the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
      event_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      event_valid  <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            src_q     <= src_addr;
            now_q     <= now_ns;
            idx_q     <= hash[IW-1:0];
            syn_path  <= !pass_in;
            pre_class <= cls_in;
            state     <= S_READ;
          end
        end
        S_READ: begin
          if (syn_path) begin
            state <= S_EVAL;
          end else begin
            result_valid  <= 1'b1;
            drop          <= 1'b0;
            pkt_class     <= pre_class;
            event_src     <= '0;
            event_ttl     <= '0;
            event_time_ns <= '0;
            state         <= S_IDLE;
          end
        end
        S_EVAL: begin
          upd   <= ev_entry;
          qprod <= {16'd0, 48'(quarantine_seconds) * 48'(NS_PER_SEC)};
          if (ev_class == CLS_NEW_QUAR) begin
            state <= S_MUL;
          end else begin
            result_valid  <= 1'b1;
            drop          <= (ev_class == CLS_QUAR_DROP);
            pkt_class     <= ev_class;
            event_src     <= '0;
            event_ttl     <= '0;
            event_time_ns <= '0;
            state         <= S_IDLE;
          end
        end
        S_MUL: begin
          result_valid  <= 1'b1;
          event_valid   <= 1'b1;
          drop          <= 1'b1;
          pkt_class     <= CLS_NEW_QUAR;
          event_src     <= src_q;
          event_ttl     <= quarantine_seconds;
          event_time_ns <= now_q;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/sfrf_table.sv
// Entry memory of the filter: one write port, one registered read port.
// Depends on sfrf_pkg.
module sfrf_table import sfrf_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data
);
  entry_t mem [TABLE_DEPTH];

  // Write and read, read data registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: hdl/sfrf_checker.sv
// Port-level checker for the SYN flood rate filter, bound to the top level.
// Depends on sfrf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sfrf_checker import sfrf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic        drop,
  input logic [2:0]  pkt_class,
  input logic        event_valid
);
  logic ev_res, drop_res, drop_cls;

  // Group the terms that the properties test.
  assign ev_res   = result_valid && (pkt_class == CLS_NEW_QUAR);
  assign drop_res = result_valid && drop;
  assign drop_cls = (pkt_class == CLS_QUAR_DROP) || (pkt_class == CLS_NEW_QUAR);

  `ASSERT_IMPL(a_event_class, clk, rst, event_valid, ev_res)
  `ASSERT_IMPL(a_drop_class, clk, rst, drop_res, drop_cls)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPL(a_result_ends, clk, rst, result_valid, !busy)
endmodule

bind syn_flood_rate_filter sfrf_checker u_sfrf_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result_valid(result_valid),
  .drop(drop), .pkt_class(pkt_class), .event_valid(event_valid)
);

// File: tb/syn_flood_rate_filter_check.sv
`timescale 1ns / 1ps
// Checker for the SYN flood rate filter: watches configuration writes, accepted
// packet summaries and result strobes, predicts each verdict and compares it.
// Depends on sfrf_pkg.
module syn_flood_rate_filter_check import sfrf_pkg::*; #(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] pkt_len,
  input  logic [15:0] ether_type,
  input  logic [3:0]  ip_ihl,
  input  logic [7:0]  ip_proto,
  input  logic [31:0] src_addr,
  input  logic [3:0]  tcp_doff,
  input  logic        flag_syn,
  input  logic        flag_ack,
  input  logic [63:0] now_ns,
  input  logic        result_valid,
  input  logic        drop,
  input  logic [2:0]  pkt_class,
  input  logic        event_valid,
  input  logic [31:0] event_src,
  input  logic [15:0] event_ttl,
  input  logic [63:0] event_time_ns,
  output int          fail_count,
  output int          pending_verdicts
);

  typedef struct packed {
    logic        drop;
    pkt_class_t  cls;
    logic        ev;
    logic [31:0] src;
    logic [15:0] ttl;
    logic [63:0] t;
  } verdict_t;

  logic [31:0] win_len;
  logic [15:0] thresh;
  logic [15:0] qsec;
  entry_t      flow_tab [DEPTH];
  verdict_t    verdict_q [$];

  assign pending_verdicts = verdict_q.size();

  function automatic verdict_t mk(logic d, pkt_class_t c);
    verdict_t v;
    v = '0;
    v.drop = d;
    v.cls = c;
    return v;
  endfunction

  // Classify one packet and update the flow table
  function automatic verdict_t judge_packet(logic [15:0] len, logic [15:0] et,
      logic [3:0] ihl, logic [7:0] pr, logic [31:0] src, logic [3:0] doff,
      logic syn, logic ack, logic [63:0] now);
    logic [31:0] ip_end;
    logic [31:0] hsh;
    int          ix;
    entry_t      e;
    verdict_t    v;
    if (len < 14 || et != ETHERTYPE_IPV4) return mk(1'b0, CLS_NON_IPV4);
    ip_end = 32'd14 + 32'(ihl) * 4;
    if (len < 34 || ip_end > 32'(len) || pr != PROTO_TCP) return mk(1'b0, CLS_NON_TCP);
    if (ip_end + 20 > 32'(len) || ip_end + 32'(doff) * 4 > 32'(len) || !(syn && !ack))
      return mk(1'b0, CLS_NOT_SYN);
    hsh = src ^ (src >> 16);
    ix = int'(hsh % DEPTH);
    e = flow_tab[ix];
    if (!e.valid || e.tag != src) begin
      e = '0;
      e.valid = 1'b1;
      e.tag = src;
      e.win_start = now;
      e.count = 17'd1;
      flow_tab[ix] = e;
      return mk(1'b0, CLS_NEW_SRC);
    end
    if (e.qactive) begin
      if (now < e.qexpiry) return mk(1'b1, CLS_QUAR_DROP);
      e.qactive = 1'b0;
    end
    if (now - e.win_start > 64'(win_len)) begin
      e.win_start = now;
      e.count = 17'd1;
      flow_tab[ix] = e;
      return mk(1'b0, CLS_WIN_RESET);
    end
    if (e.count < COUNT_MAX) e.count = e.count + 17'd1;
    if (32'(e.count) <= 32'(thresh)) begin
      flow_tab[ix] = e;
      return mk(1'b0, CLS_UNDER);
    end
    e.qactive = 1'b1;
    e.qexpiry = now + 64'(qsec) * 64'(NS_PER_SEC);
    flow_tab[ix] = e;
    v = mk(1'b1, CLS_NEW_QUAR);
    v.ev = 1'b1;
    v.src = src;
    v.ttl = qsec;
    v.t = now;
    return v;
  endfunction

  // Track configuration, predict on accept, compare on strobe
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst) begin
      win_len <= WINDOW_RST;
      thresh <= THRESH_RST;
      qsec <= QSEC_RST;
      foreach (flow_tab[i]) flow_tab[i] = '0;
      verdict_q.delete();
      fail_count <= 0;
    end else begin
      if (result_valid) begin
        if (verdict_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count <= fail_count + 1;
        end else begin
          exp_v = verdict_q.pop_front();
          if (drop !== exp_v.drop || pkt_class !== exp_v.cls
              || event_valid !== exp_v.ev || event_src !== exp_v.src
              || event_ttl !== exp_v.ttl || event_time_ns !== exp_v.t) begin
            if (drop !== exp_v.drop)
              $error("drop: expected %0d, got %0d", exp_v.drop, drop);
            if (pkt_class !== exp_v.cls)
              $error("pkt_class: expected %0d, got %0d", exp_v.cls, pkt_class);
            if (event_valid !== exp_v.ev)
              $error("event_valid: expected %0d, got %0d", exp_v.ev, event_valid);
            if (event_src !== exp_v.src)
              $error("event_src: expected %h, got %h", exp_v.src, event_src);
            if (event_ttl !== exp_v.ttl)
              $error("event_ttl: expected %0d, got %0d", exp_v.ttl, event_ttl);
            if (event_time_ns !== exp_v.t)
              $error("event_time_ns: expected %h, got %h", exp_v.t, event_time_ns);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        verdict_q.push_back(judge_packet(pkt_len, ether_type, ip_ihl, ip_proto,
            src_addr, tcp_doff, flag_syn, flag_ack, now_ns));
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: win_len <= cfg_data;
          REG_THRESH: thresh <= cfg_data[15:0];
          REG_QSEC:   qsec <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/syn_flood_rate_filter_test.sv
`timescale 1ns / 1ps
// Testbench top for the SYN flood rate filter: drives configuration and packet
// summaries with random gaps and gives the verdict. Uses sfrf_pkg, filter and checker.
module syn_flood_rate_filter_test;
  import sfrf_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        start;
  logic        busy;
  logic [15:0] pkt_len;
  logic [15:0] ether_type;
  logic [3:0]  ip_ihl;
  logic [7:0]  ip_proto;
  logic [31:0] src_addr;
  logic [3:0]  tcp_doff;
  logic        flag_syn;
  logic        flag_ack;
  logic [63:0] now_ns;
  logic        result_valid;
  logic        drop;
  logic [2:0]  pkt_class;
  logic        event_valid;
  logic [31:0] event_src;
  logic [15:0] event_ttl;
  logic [63:0] event_time_ns;
  int          fail_count;
  int          pending_verdicts;
  int          idle_cycles;
  logic [63:0] clock_ns;
  logic [31:0] flows [8];

  syn_flood_rate_filter i_dut (.*);

  syn_flood_rate_filter_check i_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles with no transaction and stop a hung run
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] ix, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = ix;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Present one summary after an optional random gap and hold it until taken
  task automatic send_pkt(logic [15:0] len, logic [15:0] et, logic [3:0] ihl,
      logic [7:0] pr, logic [31:0] src, logic [3:0] doff, logic syn, logic ack,
      logic [63:0] now, bit gap);
    int wait_n;
    wait_n = gap ? $urandom_range(0, 17) : 0;
    repeat (wait_n) @(negedge clk);
    pkt_len = len; ether_type = et; ip_ihl = ihl; ip_proto = pr;
    src_addr = src; tcp_doff = doff; flag_syn = syn; flag_ack = ack; now_ns = now;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_syn(logic [31:0] src, logic [63:0] now, bit gap);
    send_pkt(16'd60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, src, 4'd5, 1'b1, 1'b0, now, gap);
  endtask

  task automatic drain();
    while (pending_verdicts != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Random mix: mostly pure SYNs from a few flows, some malformed noise
  task automatic random_phase(int n);
    int sel;
    for (int k = 0; k < n; k++) begin
      clock_ns = clock_ns + 64'($urandom_range(0, 400));
      if ($urandom_range(0, 199) == 0) clock_ns = clock_ns + 64'($urandom) * 8;
      sel = $urandom_range(0, 9);
      if (sel < 7)
        send_syn(flows[$urandom_range(0, 7)], clock_ns, $urandom_range(0, 3) != 0);
      else if (sel < 9)
        send_pkt(16'($urandom_range(0, 120)),
            $urandom_range(0, 3) ? ETHERTYPE_IPV4 : 16'($urandom),
            4'($urandom), $urandom_range(0, 1) ? PROTO_TCP : 8'($urandom),
            flows[$urandom_range(0, 7)], 4'($urandom), 1'($urandom), 1'($urandom),
            clock_ns, 1'b1);
      else
        send_pkt(16'($urandom), 16'($urandom), 4'($urandom), 8'($urandom), $urandom,
            4'($urandom), 1'($urandom), 1'($urandom), {$urandom, $urandom}, 1'b1);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = REG_WINDOW; cfg_data = '0;
    start = 1'b0;
    pkt_len = '0; ether_type = '0; ip_ihl = '0; ip_proto = '0; src_addr = '0;
    tcp_doff = '0; flag_syn = 1'b0; flag_ack = 1'b0; now_ns = '0;
    clock_ns = 64'd1000;
    foreach (flows[i]) flows[i] = $urandom;
    flows[1] = flows[0] ^ 32'h0001_0001; // same table slot as flows[0]
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: malformed packets, field extremes and flag combinations
    write_reg(REG_THRESH, 32'd2);
    write_reg(REG_QSEC, 32'd1);
    write_reg(REG_WINDOW, 32'd1000);
    send_pkt(16'd13, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 32'd1, 4'd5, 1'b1, 1'b0, 64'd0, 1'b0);
    send_pkt(16'hFFFF, 16'hFFFF, 4'd15, 8'hFF, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1, '1, 1'b0);
    send_pkt(16'd33, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 32'd1, 4'd5, 1'b1, 1'b0, 64'd0, 1'b0);
    send_pkt(16'd53, ETHERTYPE_IPV4, 4'd0, PROTO_TCP, 32'd1, 4'd0, 1'b1, 1'b0, 64'd0, 1'b0);
    send_pkt(16'hFFFF, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 32'd0, 4'd15, 1'b1, 1'b0, 64'd0,
        1'b0);
    send_pkt(16'd60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 32'd5, 4'd5, 1'b0, 1'b0, 64'd0, 1'b0);
    send_pkt(16'd60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 32'd5, 4'd5, 1'b1, 1'b1, 64'd0, 1'b0);
    // Count up to quarantine, hold, expire, then collide and reset a window
    send_syn(flows[0], 64'd100, 1'b0);
    send_syn(flows[0], 64'd200, 1'b0);
    send_syn(flows[0], 64'd300, 1'b0);
    send_syn(flows[0], 64'd400, 1'b0);
    send_syn(flows[0], 64'd1_000_000_300, 1'b0);
    send_syn(flows[0], 64'd1_000_000_400, 1'b0);
    send_syn(flows[1], 64'd1_000_000_500, 1'b0);
    send_syn(flows[1], 64'd1_000_002_000, 1'b0);
    // Expiry sum wraps at 64 bits
    send_syn(flows[2], 64'hFFFF_FFFF_FFFF_FF00, 1'b0);
    send_syn(flows[2], 64'hFFFF_FFFF_FFFF_FF10, 1'b0);
    send_syn(flows[2], 64'hFFFF_FFFF_FFFF_FF20, 1'b0);
    send_syn(flows[2], 64'hFFFF_FFFF_FFFF_FF30, 1'b0);
    drain();

    // Random phases across register settings, extremes included
    random_phase(300);
    drain();
    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
    write_reg(REG_THRESH, 32'd1);
    write_reg(REG_QSEC, 32'd65535);
    random_phase(300);
    drain();
    write_reg(REG_WINDOW, 32'd0);
    write_reg(REG_THRESH, 32'd0);
    write_reg(REG_QSEC, 32'd0);
    random_phase(250);
    drain();
    write_reg(REG_WINDOW, 32'd3000);
    write_reg(REG_THRESH, 32'd65535);
    write_reg(REG_QSEC, 32'd60);
    random_phase(150);
    drain();
    write_reg(REG_WINDOW, 32'd20000);
    write_reg(REG_THRESH, 32'd5);
    write_reg(REG_QSEC, 32'd0);
    random_phase(230);
    drain();

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/sfrf_pkg.sv
hdl/sfrf_table.sv
hdl/syn_flood_rate_filter.sv
hdl/sfrf_checker.sv
tb/syn_flood_rate_filter_check.sv
tb/syn_flood_rate_filter_test.sv
